// ===== sv/fmrw_pkg.sv =====
// Shared types and constants for the four-motor ramp controller with command watchdog.
// Used by the top level and by its bound port checker; depends on nothing else.
`default_nettype none

package fmrw_pkg;

	localparam int NUM_MOTORS_DEF = 4;
	localparam int SPEED_MAX_DEF  = 255;
	localparam int SHOWN_MOTORS   = 4;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0]  INTERVAL_RST = 8'd5;
	localparam logic [7:0]  STEP_RST     = 8'd20;
	localparam logic [15:0] TIMEOUT_RST  = 16'd500;
	localparam logic        WDOG_EN_RST  = 1'b1;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_TICK = 2'd1,
		OP_STOP = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MOTOR = 2'd1,
		ST_BAD_DIR   = 2'd2,
		ST_WDOG      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_INTERVAL = 2'd0,
		REG_STEP     = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_WDOG_EN  = 2'd3
	} cfg_reg_t;

	// Result word as it sits on the master tdata bus, status in the lowest bits.
	typedef struct packed {
		logic [1:0] pad;
		logic [3:0] dirs;
		logic [7:0] spd4;
		logic [7:0] spd3;
		logic [7:0] spd2;
		logic [7:0] spd1;
		status_t    status;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/four_motor_ramp_watchdog.sv =====
// A result leaves the output register after its item has passed the input register.
// Throughput: one item per cycle; input register, one pass of update logic, output register.
// The input side stalls only while a finished result waits on m_tready.
// Reset (arst_n low, asynchronous): all speeds and counters zero, all directions forward,
// configuration back to interval 5, step 20, timeout 500, watchdog on.
// Top level of the ramp controller; uses fmrw_pkg.
`default_nettype none

module four_motor_ramp_watchdog import fmrw_pkg::*; #(
	parameter int NUM_MOTORS = NUM_MOTORS_DEF,
	parameter int SPEED_MAX  = SPEED_MAX_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	// [3:0] motor_number, [5:4] direction, [21:6] speed, [23:22] zero
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]             s_tuser,
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	// [1:0] status, [9:2] speed_motor_one, [17:10] speed_motor_two,
	// [25:18] speed_motor_three, [33:26] speed_motor_four,
	// [37:34] present_directions, [39:38] zero
	output      logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int SPW = $clog2(SPEED_MAX + 1);
	localparam int CW  = (SPW > 8) ? SPW : 8;
	localparam logic [CW-1:0] SPEED_MAX_C = CW'(SPEED_MAX);

	// Configuration registers.
	logic [7:0]  interval_q;
	logic [7:0]  step_q;
	logic [15:0] timeout_q;
	logic        wdog_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			step_q     <= STEP_RST;
			timeout_q  <= TIMEOUT_RST;
			wdog_en_q  <= WDOG_EN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INTERVAL: interval_q <= cfg_data[7:0];
				REG_STEP:     step_q     <= cfg_data[7:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
				REG_WDOG_EN:  wdog_en_q  <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// Pipeline control: both stages move together whenever the output can take a word.
	logic adv;
	logic valid_s1;
	logic m_tvalid_s2;

	assign adv      = !m_tvalid_s2 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = m_tvalid_s2;

	// Input register.
	opcode_t            op_s1;
	logic [3:0]         motor_s1;
	logic [1:0]         dir_s1;
	logic signed [15:0] speed_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			op_s1    <= opcode_t'(s_tuser);
			motor_s1 <= s_tdata[3:0];
			dir_s1   <= s_tdata[5:4];
			speed_s1 <= s_tdata[21:6];
		end
	end

	// Motor state.
	logic [SPW-1:0]        goal_spd_q [NUM_MOTORS];
	logic [SPW-1:0]        pres_spd_q [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] goal_dir_q;
	logic [NUM_MOTORS-1:0] pres_dir_q;
	logic [7:0]            ramp_cnt_q;
	logic [15:0]           since_q;

	logic [SPW-1:0]        goal_spd_d [NUM_MOTORS];
	logic [SPW-1:0]        pres_spd_d [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] goal_dir_d;
	logic [NUM_MOTORS-1:0] pres_dir_d;
	logic [7:0]            ramp_cnt_d;
	logic [15:0]           since_d;
	status_t               status_d;

	// Tick arithmetic.
	logic [15:0] since_inc;
	logic [7:0]  ramp_cnt_inc;
	logic        do_ramp;

	assign since_inc    = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
	assign ramp_cnt_inc = ramp_cnt_q + 8'd1;
	assign do_ramp      = (ramp_cnt_inc >= interval_q);

	// Speed request clamped to 0..SPEED_MAX.
	logic [CW-1:0] spd_clamped;

	always_comb begin
		if (speed_s1[15]) begin
			spd_clamped = '0;
		end else if ({1'b0, speed_s1} > 17'(SPEED_MAX)) begin
			spd_clamped = SPEED_MAX_C;
		end else begin
			spd_clamped = CW'(speed_s1[14:0]);
		end
	end

	// One ramp step per motor, all motors in parallel. A motor whose goal direction differs
	// from its present one ramps down and takes the new direction once it reaches zero.
	logic [CW-1:0]         step_w;
	logic [CW-1:0]         cur_w    [NUM_MOTORS];
	logic [CW-1:0]         goal_w   [NUM_MOTORS];
	logic [CW-1:0]         ramped_w [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] ramped_dir;
	logic [SPW-1:0]        pres_tick [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] dir_tick;
	logic [NUM_MOTORS-1:0] active;
	logic                  fire;

	assign step_w = CW'(step_q);

	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			cur_w[i]      = CW'(pres_spd_q[i]);
			goal_w[i]     = CW'(goal_spd_q[i]);
			ramped_w[i]   = cur_w[i];
			ramped_dir[i] = pres_dir_q[i];
			if (pres_dir_q[i] != goal_dir_q[i]) begin
				ramped_w[i] = (cur_w[i] > step_w) ? cur_w[i] - step_w : '0;
				if (ramped_w[i] == '0) begin
					ramped_dir[i] = goal_dir_q[i];
				end
			end else if (cur_w[i] < goal_w[i]) begin
				ramped_w[i] = (goal_w[i] - cur_w[i] > step_w) ? cur_w[i] + step_w : goal_w[i];
			end else if (cur_w[i] > goal_w[i]) begin
				ramped_w[i] = (cur_w[i] - goal_w[i] > step_w) ? cur_w[i] - step_w : goal_w[i];
			end
			pres_tick[i] = do_ramp ? SPW'(ramped_w[i]) : pres_spd_q[i];
			dir_tick[i]  = do_ramp ? ramped_dir[i] : pres_dir_q[i];
			active[i]    = (goal_spd_q[i] != '0) || (pres_tick[i] != '0);
		end
	end

	assign fire = wdog_en_q && (|active) && (since_inc > timeout_q);

	logic motor_ok;
	assign motor_ok = (motor_s1 != 4'd0) && (motor_s1 <= 4'(NUM_MOTORS));

	always_comb begin
		goal_spd_d = goal_spd_q;
		pres_spd_d = pres_spd_q;
		goal_dir_d = goal_dir_q;
		pres_dir_d = pres_dir_q;
		ramp_cnt_d = ramp_cnt_q;
		since_d    = since_q;
		status_d   = ST_OK;
		case (op_s1)
			OP_SET: begin
				if (!motor_ok) begin
					status_d = ST_BAD_MOTOR;
				end else begin
					since_d = '0;
					for (int i = 0; i < NUM_MOTORS; i++) begin
						if (motor_s1 == 4'(i + 1)) begin
							if (dir_s1 > 2'd1) begin
								goal_spd_d[i] = '0;
								status_d      = ST_BAD_DIR;
							end else begin
								goal_spd_d[i] = SPW'(spd_clamped);
								goal_dir_d[i] = dir_s1[0];
							end
						end
					end
				end
			end
			OP_TICK: begin
				since_d    = since_inc;
				ramp_cnt_d = do_ramp ? 8'd0 : ramp_cnt_inc;
				pres_spd_d = pres_tick;
				pres_dir_d = dir_tick;
				if (fire) begin
					for (int i = 0; i < NUM_MOTORS; i++) begin
						goal_spd_d[i] = '0;
						pres_spd_d[i] = '0;
					end
					goal_dir_d = dir_tick;
					since_d    = '0;
					status_d   = ST_WDOG;
				end
			end
			OP_STOP: begin
				for (int i = 0; i < NUM_MOTORS; i++) begin
					goal_spd_d[i] = '0;
					pres_spd_d[i] = '0;
				end
				goal_dir_d = pres_dir_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				goal_spd_q[i] <= '0;
				pres_spd_q[i] <= '0;
			end
			goal_dir_q <= '1;
			pres_dir_q <= '1;
			ramp_cnt_q <= '0;
			since_q    <= '0;
		end else if (adv && valid_s1) begin
			goal_spd_q <= goal_spd_d;
			pres_spd_q <= pres_spd_d;
			goal_dir_q <= goal_dir_d;
			pres_dir_q <= pres_dir_d;
			ramp_cnt_q <= ramp_cnt_d;
			since_q    <= since_d;
		end
	end

	// Result word: shown motors beyond NUM_MOTORS read as zero.
	logic [7:0] shown_spd [SHOWN_MOTORS];
	logic [3:0] shown_dir;

	for (genvar g = 0; g < SHOWN_MOTORS; g++) begin : g_show
		if (g < NUM_MOTORS) begin : g_on
			logic [CW-1:0] spd_w;
			assign spd_w        = CW'(pres_spd_d[g]);
			assign shown_spd[g] = spd_w[7:0];
			assign shown_dir[g] = pres_dir_d[g];
		end else begin : g_off
			assign shown_spd[g] = 8'd0;
			assign shown_dir[g] = 1'b0;
		end
	end

	result_t res_d;
	result_t res_s2;

	always_comb begin
		res_d.pad    = '0;
		res_d.dirs   = shown_dir;
		res_d.spd4   = shown_spd[3];
		res_d.spd3   = shown_spd[2];
		res_d.spd2   = shown_spd[1];
		res_d.spd1   = shown_spd[0];
		res_d.status = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_s2 <= 1'b0;
		end else if (adv) begin
			m_tvalid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_tdata = res_s2;

endmodule

`default_nettype wire

// ===== sv/fmrw_checker.sv =====
// Port-level checks for four_motor_ramp_watchdog, attached by the bind at the end.
// Depends on fmrw_pkg for the result layout and status codes.
`default_nettype none

module fmrw_checker import fmrw_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	result_t res;
	assign res = m_tdata;

	// A held result keeps its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// While a result waits, no new item may enter.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	// A new result follows an item accepted through the input register.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without an accepted item");

	// A watchdog stop leaves every motor standing.
	a_wdog_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == ST_WDOG |->
			res.spd1 == 8'd0 && res.spd2 == 8'd0 && res.spd3 == 8'd0 && res.spd4 == 8'd0)
		else $error("watchdog stop with a motor still moving");

endmodule

bind four_motor_ramp_watchdog fmrw_checker u_fmrw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb_four_motor_ramp_watchdog.sv =====
// Self-checking testbench for four_motor_ramp_watchdog: drives command, tick, stop and
// no-op words under random flow control and checks every result word against a predictor.
// Depends on fmrw_pkg and the four_motor_ramp_watchdog top level only.
module tb_four_motor_ramp_watchdog;
	timeunit 1ns;
	timeprecision 1ps;
	import fmrw_pkg::*;

	// Tracks the ramp controller state and queues the result word each input word causes.
	class ramp_tracker;
		logic [7:0]  interval_ms;
		logic [7:0]  step_size;
		logic [15:0] timeout_ms;
		logic        wdog_on;
		logic [7:0]  goal_spd [NUM_MOTORS_DEF];
		logic [7:0]  cur_spd [NUM_MOTORS_DEF];
		logic        goal_fwd [NUM_MOTORS_DEF];
		logic        cur_fwd [NUM_MOTORS_DEF];
		logic [7:0]  tick_count;
		logic [15:0] quiet_ms;
		result_t     pending_words [$];
		int          mismatches;

		function new();
			interval_ms = INTERVAL_RST;
			step_size   = STEP_RST;
			timeout_ms  = TIMEOUT_RST;
			wdog_on     = WDOG_EN_RST;
			for (int i = 0; i < NUM_MOTORS_DEF; i++) begin
				goal_spd[i] = '0;
				cur_spd[i]  = '0;
				goal_fwd[i] = 1'b1;
				cur_fwd[i]  = 1'b1;
			end
			tick_count = '0;
			quiet_ms   = '0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] val);
			case (idx)
				REG_INTERVAL: interval_ms = val[7:0];
				REG_STEP:     step_size   = val[7:0];
				REG_TIMEOUT:  timeout_ms  = val;
				REG_WDOG_EN:  wdog_on     = val[0];
				default:      ;
			endcase
		endfunction

		function void halt_all();
			for (int i = 0; i < NUM_MOTORS_DEF; i++) begin
				goal_spd[i] = '0;
				cur_spd[i]  = '0;
				goal_fwd[i] = cur_fwd[i];
			end
		endfunction

		function void apply_word(opcode_t op, logic [3:0] motor, logic [1:0] dir,
				logic [15:0] spd);
			result_t r;
			int      cur;
			int      goal;
			int      stp;
			int      m;
			logic    busy;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_SET: begin
					if (motor < 1 || motor > NUM_MOTORS_DEF) begin
						r.status = ST_BAD_MOTOR;
					end else begin
						m = motor - 1;
						quiet_ms = '0;
						if (dir > 1) begin
							goal_spd[m] = '0;
							r.status = ST_BAD_DIR;
						end else begin
							if (spd[15])
								goal_spd[m] = '0;
							else if (spd > SPEED_MAX_DEF)
								goal_spd[m] = 8'(SPEED_MAX_DEF);
							else
								goal_spd[m] = spd[7:0];
							goal_fwd[m] = dir[0];
						end
					end
				end
				OP_TICK: begin
					if (quiet_ms != 16'hFFFF)
						quiet_ms++;
					tick_count++;
					if (tick_count >= interval_ms) begin
						tick_count = '0;
						stp = step_size;
						for (int i = 0; i < NUM_MOTORS_DEF; i++) begin
							cur  = cur_spd[i];
							goal = goal_spd[i];
							// A pending reversal brakes to zero before the direction flips.
							if (cur_fwd[i] != goal_fwd[i]) begin
								cur = (cur > stp) ? cur - stp : 0;
								if (cur == 0)
									cur_fwd[i] = goal_fwd[i];
							end else if (cur < goal) begin
								cur = (goal - cur > stp) ? cur + stp : goal;
							end else if (cur > goal) begin
								cur = (cur - goal > stp) ? cur - stp : goal;
							end
							cur_spd[i] = cur[7:0];
						end
					end
					busy = 1'b0;
					for (int i = 0; i < NUM_MOTORS_DEF; i++)
						if (goal_spd[i] != 0 || cur_spd[i] != 0)
							busy = 1'b1;
					if (wdog_on && busy && quiet_ms > timeout_ms) begin
						halt_all();
						quiet_ms = '0;
						r.status = ST_WDOG;
					end
				end
				OP_STOP: halt_all();
				default: ;
			endcase
			r.spd1 = cur_spd[0];
			r.spd2 = cur_spd[1];
			r.spd3 = cur_spd[2];
			r.spd4 = cur_spd[3];
			for (int i = 0; i < NUM_MOTORS_DEF; i++)
				r.dirs[i] = cur_fwd[i];
			pending_words.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_words.pop_front();
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("speed_motor_one", want.spd1, got.spd1);
			compare_field("speed_motor_two", want.spd2, got.spd2);
			compare_field("speed_motor_three", want.spd3, got.spd3);
			compare_field("speed_motor_four", want.spd4, got.spd4);
			compare_field("present_directions", 8'(want.dirs), 8'(got.dirs));
			compare_field("pad", 8'(want.pad), 8'(got.pad));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [3:0] motor_number, [5:4] direction, [21:6] speed, [23:22] zero
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// [1:0] opcode
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [1:0] status, [9:2] .. [33:26] motor speeds one to four,
	// [37:34] present_directions, [39:38] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	int src_idle_pct = 0;
	int sink_idle_pct = 0;

	ramp_tracker tracker = new();

	four_motor_ramp_watchdog u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Receiver flow control plus sampling of both handshakes with pre-edge values.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_word(result_t'(m_tdata));
			if (s_tvalid && s_tready)
				tracker.apply_word(opcode_t'(s_tuser), s_tdata[3:0], s_tdata[5:4],
					s_tdata[21:6]);
		end
	end

	task automatic send_word(opcode_t op, logic [3:0] motor, logic [1:0] dir,
			logic [15:0] spd);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, spd, dir, motor};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random();
		opcode_t     op;
		logic [3:0]  motor;
		logic [1:0]  dir;
		logic [15:0] spd;
		int          pick;
		pick = $urandom_range(0, 99);
		op = (pick < 55) ? OP_TICK : (pick < 88) ? OP_SET : (pick < 94) ? OP_STOP : OP_NOP;
		motor = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, NUM_MOTORS_DEF))
			: 4'($urandom);
		dir = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(0, 1)) : 2'($urandom);
		case ($urandom_range(0, 9))
			0: spd = 16'($urandom);
			1: spd = 16'h8000 | 16'($urandom);
			2: spd = '0;
			default: spd = 16'($urandom_range(0, 300));
		endcase
		send_word(op, motor, dir, spd);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		tracker.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic program_regs(logic [15:0] iv, logic [15:0] st, logic [15:0] to,
			logic [15:0] en);
		write_cfg(REG_INTERVAL, iv);
		write_cfg(REG_STEP, st);
		write_cfg(REG_TIMEOUT, to);
		write_cfg(REG_WDOG_EN, en);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Caller has already lowered s_tvalid; waits for every queued result, then lets the
	// two-stage pipeline settle.
	task automatic wait_for_results();
		int n;
		n = 0;
		while (tracker.pending_words.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (tracker.pending_words.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %0d, actual 0", $time,
				tracker.pending_words.size(), tracker.pending_words.size());
			tracker.mismatches++;
			tracker.pending_words.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int src_pct, int sink_pct, logic [15:0] iv, logic [15:0] st,
			logic [15:0] to, logic [15:0] en, int count);
		wait_for_results();
		program_regs(iv, st, to, en);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (count) send_random();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset configuration: clamping, bad fields, ramps, reversal.
		send_word(OP_SET, 4'd1, 2'd1, 16'd255);
		send_word(OP_SET, 4'd2, 2'd0, 16'h7FFF);
		send_word(OP_SET, 4'd3, 2'd1, 16'hFFFF);
		send_word(OP_SET, 4'd4, 2'd0, 16'h8000);
		send_word(OP_SET, 4'd0, 2'd1, 16'd50);
		send_word(OP_SET, 4'd15, 2'd1, 16'd50);
		send_word(OP_SET, 4'd4, 2'd2, 16'd80);
		send_word(OP_SET, 4'd3, 2'd3, 16'd100);
		send_word(OP_NOP, 4'd1, 2'd1, 16'd1);
		repeat (5) send_word(OP_TICK, 4'd0, 2'd0, 16'd0);
		send_word(OP_SET, 4'd1, 2'd0, 16'd200);
		repeat (5) send_word(OP_TICK, 4'd0, 2'd0, 16'd0);
		send_word(OP_STOP, 4'd0, 2'd0, 16'd0);
		send_word(OP_TICK, 4'd0, 2'd0, 16'd0);
		send_word(OP_SET, 4'd2, 2'd1, 16'h5555);
		send_word(OP_SET, 4'd3, 2'd0, 16'h00AA);
		s_tvalid <= 1'b0;
		@(posedge clk);

		run_phase(33, 83, 16'd1, 16'd255, 16'd1, 16'd1, 238);
		run_phase(33, 83, 16'd255, 16'd1, 16'd65535, 16'd0, 238);
		run_phase(83, 33, 16'd0, 16'd0, 16'd0, 16'd1, 238);
		run_phase(83, 33, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 60)),
			16'($urandom_range(2, 15)), 16'd1, 238);
		// Junk in the upper data bits must be ignored by the narrow registers.
		run_phase(0, 0, {8'($urandom), 8'($urandom_range(1, 4))},
			{8'($urandom), 8'($urandom_range(10, 80))}, 16'($urandom_range(2, 30)),
			{15'($urandom), 1'b1}, 238);
		run_phase(0, 0, 16'($urandom_range(1, 3)), 16'($urandom_range(1, 255)),
			16'($urandom_range(1, 40)), 16'd1, 238);
		wait_for_results();

		if (tracker.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
